/* hw/rtl/ots_pkg.sv */
// Package for the oscillator trim binary search block.
// Holds phase codes, channel and register codes and shared structs; no dependencies.
`default_nettype none

package ots_pkg;

   // Widths fixed by the channel fields and registers.
   localparam int unsigned MEAS_W     = 16;
   localparam int unsigned TOL_W      = 10;
   localparam int unsigned OUT_CODE_W = 12;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned PROD_W     = 27;

   // Per mille scale of the tolerance check.
   localparam int unsigned PERMILLE = 1000;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_MHZ   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL_PERMILLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CODE     = 2'd2;

   // Register reset values.
   localparam logic [MEAS_W-1:0]     TARGET_RESET   = 16'd0;
   localparam logic [TOL_W-1:0]      TOL_RESET      = 10'd150;
   localparam logic [OUT_CODE_W-1:0] MAX_CODE_RESET = 12'd4095;

   // Input item function codes.
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_MEAS  = 1'b1;

   // Result item kinds.
   localparam logic KIND_PROBE = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   // Sequencer phases.
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_SEARCH = 3'd1,
      PH_MLOW   = 3'd2,
      PH_MHIGH  = 3'd3,
      PH_FINAL  = 3'd4
   } phase_type;

   // Scaled tolerance limits: a reading m passes when
   // m*1000 + 999 >= lo_prod and m*1000 <= hi_prod.
   typedef struct packed {
      logic [PROD_W-1:0] lo_prod;
      logic [PROD_W-1:0] hi_prod;
   } limit_type;

   // One result produced by the sequencer step.
   typedef struct packed {
      logic                  valid;
      logic                  kind;
      logic [OUT_CODE_W-1:0] code;
      logic                  pass;
   } result_type;

endpackage : ots_pkg

`default_nettype wire

/* hw/rtl/ots_limits.sv */
// Registered tolerance limit products for the final pass check.
// Depends on ots_pkg for widths and the limit struct.
`default_nettype none

module ots_limits
   import ots_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [MEAS_W-1:0] target_mhz,
   input  wire logic [TOL_W-1:0]  tol_permille,
   output limit_type              limits
);

   logic [TOL_W-1:0]  lo_factor;
   logic [TOL_W:0]    hi_factor;
   logic [PROD_W-1:0] lo_prod_in;
   logic [PROD_W-1:0] hi_prod_in;
   limit_type         limits_ff;

   // Lower factor saturates at zero for tolerances above the full scale.
   always_comb begin
      if ({1'b0, tol_permille} < (TOL_W+1)'(PERMILLE)) begin
         lo_factor = TOL_W'((TOL_W+1)'(PERMILLE) - {1'b0, tol_permille});
      end else begin
         lo_factor = '0;
      end
      hi_factor  = (TOL_W+1)'(PERMILLE) + {1'b0, tol_permille};
      lo_prod_in = PROD_W'(target_mhz) * PROD_W'(lo_factor);
      hi_prod_in = PROD_W'(target_mhz) * PROD_W'(hi_factor);
   end

   // The registers change only with configuration, long before a final reading.
   always_ff @(posedge clock) begin
      limits_ff.lo_prod <= lo_prod_in;
      limits_ff.hi_prod <= hi_prod_in;
   end

   assign limits = limits_ff;

endmodule : ots_limits

`default_nettype wire

/* hw/rtl/ots_seq.sv */
// Binary search sequencer: bounds, probe code, phase and at most one result per step.
// Depends on ots_pkg for phase codes, limits and the result struct.
`default_nettype none

module ots_seq
   import ots_pkg::*;
#(
   parameter int unsigned CODE_BITS = 12
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step_en,
   input  wire logic                  func,
   input  wire logic [MEAS_W-1:0]     measured_mhz,
   input  wire logic [MEAS_W-1:0]     target_mhz,
   input  wire logic [CODE_BITS-1:0]  max_code,
   input  wire limit_type             limits,
   output result_type                 result
);

   phase_type            phase_ff, phase_in;
   logic [CODE_BITS-1:0] low_ff, low_in;
   logic [CODE_BITS-1:0] high_ff, high_in;
   logic [CODE_BITS-1:0] probe_ff, probe_in;
   logic [MEAS_W-1:0]    low_err_ff, low_err_in;

   logic [MEAS_W-1:0]    meas_err;
   logic                 meas_above;
   logic [CODE_BITS:0]   bound_sum;
   logic [CODE_BITS-1:0] mid_code;
   logic                 converged;
   logic [PROD_W-1:0]    meas_scaled;
   logic                 in_tol;

   // Absolute error of the reading against the target.
   always_comb begin
      meas_above = measured_mhz > target_mhz;
      if (meas_above) begin
         meas_err = measured_mhz - target_mhz;
      end else begin
         meas_err = target_mhz - measured_mhz;
      end
   end

   // Tolerance check against the prescaled limits, no division needed.
   always_comb begin
      meas_scaled = PROD_W'(measured_mhz) * PROD_W'(PERMILLE);
      in_tol = (meas_scaled + PROD_W'(PERMILLE - 1) >= limits.lo_prod) &&
               (meas_scaled <= limits.hi_prod);
   end

   // Bound and saved error updates.
   always_comb begin
      low_in     = low_ff;
      high_in    = high_ff;
      low_err_in = low_err_ff;
      if (step_en) begin
         if (func == FUNC_START) begin
            low_in  = '0;
            high_in = max_code;
         end else begin
            case (phase_ff)
               PH_SEARCH: begin
                  if (meas_above) begin
                     high_in = probe_ff;
                  end else begin
                     low_in = probe_ff;
                  end
               end
               PH_MLOW: begin
                  low_err_in = meas_err;
               end
               default: begin
               end
            endcase
         end
      end
      bound_sum = {1'b0, low_in} + {1'b0, high_in};
      mid_code  = bound_sum[CODE_BITS:1];
      converged = mid_code == low_in;
   end

   // Next phase and probe code.
   always_comb begin
      phase_in = phase_ff;
      probe_in = probe_ff;
      if (step_en) begin
         if (func == FUNC_START) begin
            phase_in = converged ? PH_MLOW : PH_SEARCH;
            probe_in = converged ? low_in : mid_code;
         end else begin
            case (phase_ff)
               PH_SEARCH: begin
                  phase_in = converged ? PH_MLOW : PH_SEARCH;
                  probe_in = converged ? low_in : mid_code;
               end
               PH_MLOW: begin
                  phase_in = PH_MHIGH;
                  probe_in = high_ff;
               end
               PH_MHIGH: begin
                  phase_in = PH_FINAL;
                  probe_in = (low_err_ff < meas_err) ? low_ff : high_ff;
               end
               PH_FINAL: begin
                  phase_in = PH_IDLE;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Result of this step; a reading while idle gives none.
   always_comb begin
      result.valid = step_en && ((func == FUNC_START) || (phase_ff != PH_IDLE));
      result.kind  = ((func == FUNC_MEAS) && (phase_ff == PH_FINAL)) ?
                     KIND_DONE : KIND_PROBE;
      result.code  = OUT_CODE_W'(probe_in);
      result.pass  = (result.kind == KIND_DONE) && in_tol;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         low_ff     <= '0;
         high_ff    <= '0;
         probe_ff   <= '0;
         low_err_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         low_ff     <= low_in;
         high_ff    <= high_in;
         probe_ff   <= probe_in;
         low_err_ff <= low_err_in;
      end
   end

   // A done result only comes out of the final measurement.
   a_done_from_final: assert property (@(posedge clock) disable iff (reset)
      result.valid && (result.kind == KIND_DONE) |-> phase_ff == PH_FINAL)
      else $error("done result outside final phase");

   // The final measurement always returns the sequencer to idle.
   a_final_to_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && (func == FUNC_MEAS) && (phase_ff == PH_FINAL) |=> phase_ff == PH_IDLE)
      else $error("sequencer did not return to idle");

   // While searching, the bounds never cross.
   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SEARCH |-> low_ff <= high_ff)
      else $error("search bounds crossed");

endmodule : ots_seq

`default_nettype wire

/* hw/rtl/oscillator_trim_binary_search_top.sv */
// Top level of the oscillator trim binary search block: registers, channels, stages.
// Depends on ots_pkg, ots_limits and ots_seq.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   req_func, req_measured_mhz
//   rsp_      out        rsp_valid/rsp_ready   rsp_kind, rsp_code, rsp_pass
//   csr_      in         csr_wr_en             csr_index, csr_wdata
//
// One item is taken per cycle unless the input register is full behind a stall;
// the input register takes it at the transfer and the sequencer step then loads the
// result register, from which the result transfer is made. A stalled result register
// holds the sequencer step; the input register still takes one more item. Limit
// products are registered from configuration. Synchronous reset clears the phase,
// valid flags, sequencer and config registers to defaults; data registers are kept.
`default_nettype none

module oscillator_trim_binary_search_top
   import ots_pkg::*;
#(
   parameter int unsigned CODE_BITS = 12
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_func,
   input  wire logic [MEAS_W-1:0]     req_measured_mhz,
   // Result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_kind,
   output logic [OUT_CODE_W-1:0]      rsp_code,
   output logic                       rsp_pass,
   // Configuration port
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [MEAS_W-1:0]     target_ff;
   logic [TOL_W-1:0]      tol_ff;
   logic [OUT_CODE_W-1:0] max_code_ff;

   logic                  in_valid_ff, in_valid_in;
   logic                  in_func_ff;
   logic [MEAS_W-1:0]     in_meas_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff;

   logic                  req_xfer;
   logic                  step_go;
   logic                  step_en;
   limit_type             limits;
   result_type            result;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= TARGET_RESET;
         tol_ff      <= TOL_RESET;
         max_code_ff <= MAX_CODE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TARGET_MHZ:   target_ff   <= csr_wdata[MEAS_W-1:0];
            CSR_TOL_PERMILLE: tol_ff      <= csr_wdata[TOL_W-1:0];
            CSR_MAX_CODE:     max_code_ff <= csr_wdata[OUT_CODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Handshake: the step runs when the result register is free or draining.
   assign step_go   = !rsp_valid_ff || rsp_ready;
   assign step_en   = in_valid_ff && step_go;
   assign req_ready = !in_valid_ff || step_go;
   assign req_xfer  = req_valid && req_ready;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_func_ff <= req_func;
         in_meas_ff <= req_measured_mhz;
      end
   end

   ots_limits u_limits (
      .clock        (clock),
      .target_mhz   (target_ff),
      .tol_permille (tol_ff),
      .limits       (limits)
   );

   ots_seq #(
      .CODE_BITS (CODE_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .func         (in_func_ff),
      .measured_mhz (in_meas_ff),
      .target_mhz   (target_ff),
      .max_code     (CODE_BITS'(max_code_ff)),
      .limits       (limits),
      .result       (result)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step_go) begin
         rsp_valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_ff.kind;
   assign rsp_code  = rsp_ff.code;
   assign rsp_pass  = rsp_ff.pass;

   // The sequencer never steps over a result that is still waiting.
   a_step_needs_slot: assert property (@(posedge clock) disable iff (reset)
      step_en |-> !rsp_valid_ff || rsp_ready)
      else $error("step taken while result register blocked");

   // A full input register behind a stalled result blocks new transfers.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready && in_valid_ff |-> !req_ready)
      else $error("input taken while pipeline stalled");

   // Every accepted item lands in the input register.
   a_xfer_loads: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> in_valid_ff)
      else $error("accepted item lost");

endmodule : oscillator_trim_binary_search_top

`default_nettype wire
